// ===== hw/rtl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RawW  = 24;
  localparam int unsigned CalW  = 16;
  localparam int unsigned OssW  = 2;

  // Compensation constants of the integer scheme.
  localparam logic [DataW-1:0] TempBase   = 32'd4000;
  localparam logic [DataW-1:0] PrsSqCoef  = 32'd3038;
  localparam logic [DataW-1:0] PrsLinCoef = 32'hFFFF_E343;  // -7357
  localparam logic [DataW-1:0] PrsOffset  = 32'd3791;
  localparam logic [DataW-1:0] PrsScale   = 32'd50000;
  localparam logic [DataW-1:0] PrsBias    = 32'd32768;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegOffsetWords = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCurveWords  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSensScale   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTempGain    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTempOffset  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCurveNum    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCurveDen    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOversample  = 3'd7;

  localparam logic KindTemp  = 1'b0;
  localparam logic KindPress = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_USE  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  // Multiply steps of the sequencer.
  typedef enum logic [3:0] {
    M_T_X1,
    M_P_SQ,
    M_P_X1,
    M_P_X2,
    M_P_X3,
    M_P_X4,
    M_P_B4,
    M_P_B7,
    M_P_HH,
    M_P_X5,
    M_P_X6
  } step_e;

  function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] v, input int unsigned s);
    return DataW'($signed(v) >>> s);
  endfunction

  function automatic logic [DataW-1:0] sx16(input logic [CalW-1:0] v);
    return {{(DataW-CalW){v[CalW-1]}}, v};
  endfunction

endpackage

// ===== hw/rtl/bsc_div.sv =====
module bsc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bsc_pkg::DataW-1:0] dividend_i,
  input  logic [bsc_pkg::DataW-1:0] divisor_i,
  output logic                      done_o,
  output logic [bsc_pkg::DataW-1:0] quotient_o
);
  import bsc_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DataW:0]   rem_shift, diff;
  logic             ge;

  // Restoring division, one quotient bit a cycle; the dividend shifts out of
  // the quotient register as the quotient bits shift in.
  always_comb begin
    rem_shift = {rem_q, quo_q[DataW-1]};
    diff      = rem_shift - {1'b0, dvs_q};
    ge        = !diff[DataW];
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DataW-1:0] : rem_shift[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/barometric_sensor_compensation.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   sample_kind_i, raw_sample_i
// out      output     out_valid_o/out_ready_i result_kind_o, result_value_o, divide_error_o
// cfg      input      cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// One 32x32 multiplier and one radix-2 divider are shared under a sequencer.
// Each multiply passes through S_MUL (product) and then S_USE (use); a division
// runs in the divider while the sequencer waits in S_DIV, and a result waits in
// S_OUT for out_ready_i. One item is in work at a time.
// Reset clears the calibration registers and the kept temperature intermediate.
module barometric_sensor_compensation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        sample_kind_i,
  input  logic [bsc_pkg::RawW-1:0]    raw_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic signed [bsc_pkg::DataW-1:0] result_value_o,
  output logic                        divide_error_o,
  input  logic                        cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bsc_pkg::CfgW-1:0]    cfg_wdata_i
);
  import bsc_pkg::*;

  logic [CfgW-1:0]  offs_q;
  logic [DataW-1:0] curve_q;
  logic [CalW-1:0]  ac4_q, ac5_q, ac6_q, mc_q, md_q;
  logic [OssW-1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q  <= '0;
      curve_q <= '0;
      ac4_q   <= '0;
      ac5_q   <= '0;
      ac6_q   <= '0;
      mc_q    <= '0;
      md_q    <= '0;
      oss_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOffsetWords: offs_q  <= cfg_wdata_i;
        RegCurveWords:  curve_q <= cfg_wdata_i[DataW-1:0];
        RegSensScale:   ac4_q   <= cfg_wdata_i[CalW-1:0];
        RegTempGain:    ac5_q   <= cfg_wdata_i[CalW-1:0];
        RegTempOffset:  ac6_q   <= cfg_wdata_i[CalW-1:0];
        RegCurveNum:    mc_q    <= cfg_wdata_i[CalW-1:0];
        RegCurveDen:    md_q    <= cfg_wdata_i[CalW-1:0];
        RegOversample:  oss_q   <= cfg_wdata_i[OssW-1:0];
        default:        ;
      endcase
    end
  end

  logic [DataW-1:0] ac1, ac2, ac3, b1, b2;
  assign ac1 = sx16(offs_q[47:32]);
  assign ac2 = sx16(offs_q[31:16]);
  assign ac3 = sx16(offs_q[15:0]);
  assign b1  = sx16(curve_q[31:16]);
  assign b2  = sx16(curve_q[15:0]);

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   kind_q, kind_d, neg_q, neg_d, err_q, err_d;
  logic [RawW-1:0]  raw_q, raw_d;
  logic [DataW-1:0] prod_q, prod_d, x_q, x_d, acc_q, acc_d, sq_q, sq_d;
  logic [DataW-1:0] b3_q, b3_d, b4_q, b4_d, b7_q, b7_d, p_q, p_d;
  logic [DataW-1:0] ti_q, ti_d, val_q, val_d;

  logic [DataW-1:0] op_a, op_b, b6, up, h, x1, den, num, x3, tmp, q_s, b5;
  logic [DataW-1:0] dvd, dvs, quo;
  logic             div_start, div_done;

  bsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign b6 = ti_q - TempBase;
  assign up = DataW'(raw_q) >> (4'd8 - {2'b00, oss_q});
  assign h  = asr(p_q, 8);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (step_q)
      M_T_X1: begin op_a = {16'd0, raw_q[15:0]} - {16'd0, ac6_q}; op_b = {16'd0, ac5_q}; end
      M_P_SQ: begin op_a = b6;            op_b = b6;  end
      M_P_X1: begin op_a = b2;            op_b = sq_q; end
      M_P_X2: begin op_a = ac2;           op_b = b6;  end
      M_P_X3: begin op_a = ac3;           op_b = b6;  end
      M_P_X4: begin op_a = b1;            op_b = sq_q; end
      M_P_B4: begin op_a = {16'd0, ac4_q}; op_b = acc_q + PrsBias; end
      M_P_B7: begin op_a = up - b3_q;     op_b = PrsScale >> oss_q; end
      M_P_HH: begin op_a = h;             op_b = h;   end
      M_P_X5: begin op_a = x_q;           op_b = PrsSqCoef; end
      M_P_X6: begin op_a = PrsLinCoef;    op_b = p_q; end
      default: begin op_a = '0;           op_b = '0;  end
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    kind_d  = kind_q;
    raw_d   = raw_q;
    neg_d   = neg_q;
    err_d   = err_q;
    prod_d  = prod_q;
    x_d     = x_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    b3_d    = b3_q;
    b4_d    = b4_q;
    b7_d    = b7_q;
    p_d     = p_q;
    ti_d    = ti_q;
    val_d   = val_q;
    div_start = 1'b0;
    dvd = '0;
    dvs = '0;
    x1  = asr(prod_q, 15);
    den = x1 + sx16(md_q);
    num = sx16(mc_q) << 11;
    x3  = x_q + asr(prod_q, 11);
    tmp = ((ac1 << 2) + x3) << oss_q;
    q_s = neg_q ? (32'd0 - quo) : quo;
    b5  = x_q + q_s;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = sample_kind_i;
          raw_d   = raw_sample_i;
          err_d   = 1'b0;
          val_d   = '0;
          step_d  = (sample_kind_i == KindTemp) ? M_T_X1 : M_P_SQ;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = op_a * op_b;
        state_d = S_USE;
      end
      S_USE: begin
        state_d = S_MUL;
        unique case (step_q)
          M_T_X1: begin
            x_d = x1;
            if (den == '0) begin
              err_d   = 1'b1;
              state_d = S_OUT;
            end else begin
              neg_d     = num[DataW-1] ^ den[DataW-1];
              dvd       = num[DataW-1] ? (32'd0 - num) : num;
              dvs       = den[DataW-1] ? (32'd0 - den) : den;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          M_P_SQ: begin sq_d = asr(prod_q, 12); step_d = M_P_X1; end
          M_P_X1: begin x_d = asr(prod_q, 11);  step_d = M_P_X2; end
          M_P_X2: begin b3_d = asr(tmp + 32'd2, 2); step_d = M_P_X3; end
          M_P_X3: begin x_d = asr(prod_q, 13);  step_d = M_P_X4; end
          M_P_X4: begin
            acc_d  = asr(x_q + asr(prod_q, 16) + 32'd2, 2);
            step_d = M_P_B4;
          end
          M_P_B4: begin b4_d = prod_q >> 15; step_d = M_P_B7; end
          M_P_B7: begin
            b7_d = prod_q;
            if (b4_q == '0) begin
              err_d   = 1'b1;
              state_d = S_OUT;
            end else begin
              // Doubling before the divide would overflow when the top bit is set.
              dvd       = prod_q[DataW-1] ? prod_q : (prod_q << 1);
              dvs       = b4_q;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          M_P_HH: begin x_d = prod_q; step_d = M_P_X5; end
          M_P_X5: begin acc_d = asr(prod_q, 16); step_d = M_P_X6; end
          M_P_X6: begin
            val_d   = p_q + asr(acc_q + asr(prod_q, 16) + PrsOffset, 4);
            state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          if (kind_q == KindTemp) begin
            ti_d    = b5;
            val_d   = asr(b5 + 32'd8, 4);
            state_d = S_OUT;
          end else begin
            p_d     = b7_q[DataW-1] ? (quo << 1) : quo;
            step_d  = M_P_HH;
            state_d = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= M_T_X1;
      ti_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ti_q    <= ti_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    raw_q  <= raw_d;
    neg_q  <= neg_d;
    err_q  <= err_d;
    prod_q <= prod_d;
    x_q    <= x_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    b3_q   <= b3_d;
    b4_q   <= b4_d;
    b7_q   <= b7_d;
    p_q    <= p_d;
    val_q  <= val_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign result_kind_o  = kind_q;
  assign result_value_o = $signed(val_q);
  assign divide_error_o = err_q;

endmodule
